[design/rtu_crc_pkg.sv]
// types, constants and crc function shared by the rtu frame deframer
package rtu_crc_pkg;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic        end_of_frame;
    logic [15:0] transaction_number;
  } byte_item_t;

  typedef struct packed {
    logic [7:0]  payload_byte;
    logic        payload_valid;
    logic        frame_done;
    logic [1:0]  frame_status;
    logic [7:0]  unit_address;
    logic [15:0] transaction_echo;
  } result_item_t;

  // one registered input item as it travels from the ingress register to the core
  typedef struct packed {
    logic       valid;
    byte_item_t item;
  } stage_t;

  localparam logic [1:0]  STATUS_OK        = 2'd0;
  localparam logic [1:0]  STATUS_SHORT     = 2'd1;
  localparam logic [1:0]  STATUS_CRC_ERROR = 2'd2;

  localparam logic [2:0]  MIN_FRAME_LEN    = 3'd4;
  localparam logic [2:0]  RELEASE_COUNT    = 3'd3;
  localparam logic [15:0] CRC_INIT         = 16'hFFFF;
  localparam logic [15:0] CRC_POLY         = 16'hA001;

  // reflected crc-16, one byte folded in over eight shift steps
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

[design/rtu_crc_ingress.sv]
// input register stage that holds one byte item for the core
module rtu_crc_ingress (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    byte_valid,
  output logic                    byte_stall,
  input  rtu_crc_pkg::byte_item_t byte_item,
  output rtu_crc_pkg::stage_t     stage,
  input  logic                    take
);
  import rtu_crc_pkg::*;

  logic       held_valid;
  byte_item_t held_item;

  // hold while an item sits here that the core cannot take yet
  assign byte_stall = held_valid && !take;
  assign stage      = '{valid: held_valid, item: held_item};

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (!byte_stall) begin
      held_valid <= byte_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!byte_stall) begin
      held_item <= byte_item;
    end
  end

endmodule

[design/rtu_crc_core.sv]
// frame state, crc update, holdback and result register
module rtu_crc_core (
  input  logic                      clk,
  input  logic                      rst,
  input  rtu_crc_pkg::stage_t       stage,
  output logic                      take,
  output logic                      result_valid,
  input  logic                      result_stall,
  output rtu_crc_pkg::result_item_t result_item
);
  import rtu_crc_pkg::*;

  logic [15:0]  crc_reg;
  logic [7:0]   holdback [2];
  logic [2:0]   byte_count;
  logic [7:0]   address_reg;
  logic [15:0]  transaction_reg;

  logic [15:0]  crc_next;
  logic [2:0]   byte_count_next;
  logic [7:0]   address_next;
  logic [15:0]  transaction_next;
  logic         first_byte;
  logic         release_byte;
  logic         eof;
  logic         has_result;
  logic         out_free;
  logic [1:0]   status;
  result_item_t result_next;

  assign eof          = stage.item.end_of_frame;
  assign first_byte   = (byte_count == 3'd0);
  assign release_byte = (byte_count >= RELEASE_COUNT);
  assign has_result   = release_byte || eof;
  assign out_free     = !result_valid || !result_stall;
  assign take         = stage.valid && (out_free || !has_result);

  assign crc_next         = crc16_byte(crc_reg, stage.item.data_byte);
  assign address_next     = first_byte ? stage.item.data_byte : address_reg;
  assign transaction_next = first_byte ? stage.item.transaction_number : transaction_reg;
  assign byte_count_next  = (byte_count < MIN_FRAME_LEN) ? byte_count + 3'd1 : byte_count;

  always_comb begin
    status = STATUS_OK;
    if (eof) begin
      if (byte_count_next < MIN_FRAME_LEN) begin
        status = STATUS_SHORT;
      end else if (crc_next != 16'h0000) begin
        status = STATUS_CRC_ERROR;
      end
    end
  end

  always_comb begin
    result_next.payload_byte     = release_byte ? holdback[0] : 8'h00;
    result_next.payload_valid    = release_byte;
    result_next.frame_done       = eof;
    result_next.frame_status     = status;
    result_next.unit_address     = address_next;
    result_next.transaction_echo = transaction_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      crc_reg         <= CRC_INIT;
      holdback[0]     <= 8'h00;
      holdback[1]     <= 8'h00;
      byte_count      <= 3'd0;
      address_reg     <= 8'h00;
      transaction_reg <= 16'h0000;
    end else if (take) begin
      address_reg     <= address_next;
      transaction_reg <= transaction_next;
      if (eof) begin
        crc_reg     <= CRC_INIT;
        byte_count  <= 3'd0;
        holdback[0] <= 8'h00;
        holdback[1] <= 8'h00;
      end else begin
        crc_reg    <= crc_next;
        byte_count <= byte_count_next;
        if (!first_byte) begin
          holdback[0] <= holdback[1];
          holdback[1] <= stage.item.data_byte;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (out_free) begin
      result_valid <= take && has_result;
    end
  end

  always_ff @(posedge clk) begin
    if (take && has_result) begin
      result_item <= result_next;
    end
  end

endmodule

[design/rtu_frame_crc_checker_deframer.sv]
// top level of the rtu frame deframer with crc-16 check
//
// byte channel: one frame byte per item, with an end-of-frame mark and a
//   transaction number that is sampled on the frame's first byte
// result channel: one item per released payload byte and one on the last
//   byte of each frame (both may share an item); bytes with no result are
//   absorbed silently
// the first byte of a frame becomes the unit address; later bytes pass a
//   two-byte holdback so the trailing crc pair never comes out
// the crc runs over every byte, crc included; a residue of zero means ok,
//   otherwise the status is crc error, and frames under four bytes are short
// payload is released before the check, so downstream drops failed frames
// path: a byte passes the input register, then the crc and holdback logic
//   into the result register
// throughput: one byte per cycle when not stalled, set by the byte-wide unrolled crc step
// reset: frame state clears, crc back to all ones, both channels empty
// a stalled result holds; bytes that yield no result keep flowing, and a
//   byte that yields one waits in the input register, stalling the sender
module rtu_frame_crc_checker_deframer (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      byte_valid,
  output logic                      byte_stall,
  input  rtu_crc_pkg::byte_item_t   byte_item,
  output logic                      result_valid,
  input  logic                      result_stall,
  output rtu_crc_pkg::result_item_t result_item
);
  import rtu_crc_pkg::*;

  // registered byte item handed to the core
  stage_t stage;
  // core consumes the registered byte this cycle
  logic   take;

  rtu_crc_ingress u_ingress (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .byte_stall (byte_stall),
    .byte_item  (byte_item),
    .stage      (stage),
    .take       (take)
  );

  // crc, holdback, status and the result register
  rtu_crc_core u_core (
    .clk          (clk),
    .rst          (rst),
    .stage        (stage),
    .take         (take),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_item  (result_item)
  );

endmodule

[design/rtu_crc_checker.sv]
// port-level checks for the rtu frame deframer and their bind
module rtu_crc_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      result_valid,
  input logic                      result_stall,
  input rtu_crc_pkg::result_item_t result_item
);
  import rtu_crc_pkg::*;

  // a stalled result stays put
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result_item))
    else $error("stalled result changed");

  // every result carries a byte or closes a frame
  a_result_nonempty: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> result_item.payload_valid || result_item.frame_done)
    else $error("empty result item");

  // status only on frame end, and a short frame never releases payload
  a_status_scope: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_item.frame_done |-> result_item.frame_status == STATUS_OK)
    else $error("status outside frame end");

  a_short_no_payload: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_item.payload_valid
      |-> result_item.frame_status != STATUS_SHORT)
    else $error("payload released in a short frame");

  // nothing comes out in the cycle right after reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result after reset");

endmodule

bind rtu_frame_crc_checker_deframer rtu_crc_checker u_checker (
  .clk          (clk),
  .rst          (rst),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .result_item  (result_item)
);
